// File: rtl/core/gmum_pkg.sv
// ----------------------------------------------------------------------------
// gmum_pkg: shared types for the grid maze union-merge block
// Result codes, direction codes and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package gmum_pkg;

  // width of a grid coordinate on the channels
  localparam int unsigned COORD_W = 4;

  // item kind code for a grid restart (anything else is a carve attempt)
  localparam logic KIND_RESTART = 1'b0;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_REJECT = 2'd0,
    STATUS_SAME   = 2'd1,
    STATUS_OPENED = 2'd2,
    STATUS_IDLE   = 2'd3
  } status_e;

  // carve direction codes
  typedef enum logic [1:0] {
    DIR_ROW_INC = 2'd0,
    DIR_COL_INC = 2'd1,
    DIR_ROW_DEC = 2'd2,
    DIR_COL_DEC = 2'd3
  } dir_e;

  // RAM read address select
  typedef enum logic [1:0] {
    RSEL_SCAN  = 2'd0,
    RSEL_START = 2'd1,
    RSEL_WALL  = 2'd2,
    RSEL_FAR   = 2'd3
  } rd_sel_e;

  // controller -> datapath commands
  typedef struct packed {
    logic    load;          // capture an accepted beat
    rd_sel_e rd_sel;        // which cell to read this cycle
    logic    cap_start;     // read data belongs to the start cell
    logic    cap_wall;      // read data belongs to the wall cell
    logic    cap_far;       // read data belongs to the far cell
    logic    wall_wr;       // open the wall with the larger label
    logic    scan_clr;      // rewind the sweep counters
    logic    init_step;     // write one cell of the initial grid
    logic    relabel_step;  // read one cell for relabeling
    logic    fin_load;      // update the finished flag
    logic    res_load;      // load the result register
    status_e res_status;    // status code for the result
  } ctrl_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic bounds_ok;   // start, wall and far cell of the offered beat in grid
    logic finished;    // all open cells share the last label
    logic scan_last;   // sweep counter on the last cell
    logic start_open;  // start cell is open
    logic merge_ok;    // wall closed, far cell open, labels differ
  } dp_stat_t;

endpackage

// File: rtl/core/gmum_in_if.sv
// ----------------------------------------------------------------------------
// gmum_in_if: request channel
// Valid/ready channel carrying one restart or carve attempt per beat.
// ----------------------------------------------------------------------------
interface gmum_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [gmum_pkg::COORD_W-1:0] cell_row;
  logic [gmum_pkg::COORD_W-1:0] cell_col;
  logic [1:0]                   direction;

  modport source (output valid, kind, cell_row, cell_col, direction, input ready);
  modport sink   (input valid, kind, cell_row, cell_col, direction, output ready);
endinterface

// File: rtl/core/gmum_out_if.sv
// ----------------------------------------------------------------------------
// gmum_out_if: result channel
// Valid/ready channel carrying one result beat per request.
// ----------------------------------------------------------------------------
interface gmum_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [gmum_pkg::COORD_W-1:0] wall_row;
  logic [gmum_pkg::COORD_W-1:0] wall_col;
  logic                         done_res;

  modport source (output valid, status, wall_row, wall_col, done_res, input ready);
  modport sink   (input valid, status, wall_row, wall_col, done_res, output ready);
endinterface

// File: rtl/core/gmum_ram.sv
// ----------------------------------------------------------------------------
// gmum_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gmum_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/gmum_ctrl.sv
// ----------------------------------------------------------------------------
// gmum_ctrl: sequencing controller
// Walks each beat through dispatch, cell reads, merge decision, relabel
// sweep and result hand-off; also runs the grid init sweep.
// ----------------------------------------------------------------------------
module gmum_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_kind_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  gmum_pkg::dp_stat_t   stat_i,
  output gmum_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_BOOT,
    ST_IDLE,
    ST_RESTART,
    ST_RD_START,
    ST_RD_WALL,
    ST_RD_FAR,
    ST_RD_LAST,
    ST_CHECK,
    ST_SCAN,
    ST_TAIL,
    ST_REPORT
  } state_e;

  state_e              state_q, state_d;
  gmum_pkg::status_e   status_q, status_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                out_free;
  gmum_pkg::ctrl_cmd_t cmd;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // next state and commands
  always_comb begin
    state_d        = state_q;
    status_d       = status_q;
    cmd            = '0;
    cmd.rd_sel     = gmum_pkg::RSEL_SCAN;
    cmd.res_status = status_q;

    unique case (state_q)
      ST_BOOT: begin
        cmd.init_step = 1'b1;
        if (stat_i.scan_last) begin
          cmd.fin_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.scan_clr = 1'b1;
        if (accept) begin
          cmd.load = 1'b1;
          if (in_kind_i == gmum_pkg::KIND_RESTART) begin
            state_d = ST_RESTART;
          end else if (stat_i.finished) begin
            status_d = gmum_pkg::STATUS_IDLE;
            state_d  = ST_REPORT;
          end else if (!stat_i.bounds_ok) begin
            status_d = gmum_pkg::STATUS_REJECT;
            state_d  = ST_REPORT;
          end else begin
            state_d = ST_RD_START;
          end
        end
      end
      ST_RESTART: begin
        cmd.init_step = 1'b1;
        if (stat_i.scan_last) begin
          cmd.fin_load = 1'b1;
          status_d     = gmum_pkg::STATUS_IDLE;
          state_d      = ST_REPORT;
        end
      end
      ST_RD_START: begin
        cmd.rd_sel = gmum_pkg::RSEL_START;
        state_d    = ST_RD_WALL;
      end
      ST_RD_WALL: begin
        cmd.rd_sel    = gmum_pkg::RSEL_WALL;
        cmd.cap_start = 1'b1;
        state_d       = ST_RD_FAR;
      end
      ST_RD_FAR: begin
        cmd.rd_sel   = gmum_pkg::RSEL_FAR;
        cmd.cap_wall = 1'b1;
        state_d      = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        cmd.cap_far = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        if (!stat_i.start_open) begin
          status_d = gmum_pkg::STATUS_REJECT;
          state_d  = ST_REPORT;
        end else if (!stat_i.merge_ok) begin
          status_d = gmum_pkg::STATUS_SAME;
          state_d  = ST_REPORT;
        end else begin
          cmd.wall_wr = 1'b1;
          status_d    = gmum_pkg::STATUS_OPENED;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.relabel_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        // last read returns here; its write and the done check finish now
        cmd.fin_load = 1'b1;
        state_d      = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // output beat valid
    if (cmd.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_BOOT;
      status_q    <= gmum_pkg::STATUS_REJECT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/gmum_dp.sv
// ----------------------------------------------------------------------------
// gmum_dp: grid datapath
// Cell RAM (open bit and group label), coordinate and address logic,
// sweep counters for init and relabel, done tracking and result register.
// ----------------------------------------------------------------------------
module gmum_dp #(
  parameter int unsigned GRID_SIDE = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gmum_pkg::ctrl_cmd_t          cmd_i,
  output gmum_pkg::dp_stat_t           stat_o,
  input  logic [gmum_pkg::COORD_W-1:0] cell_row_i,
  input  logic [gmum_pkg::COORD_W-1:0] cell_col_i,
  input  logic [1:0]                   direction_i,
  output logic [1:0]                   status_o,
  output logic [gmum_pkg::COORD_W-1:0] wall_row_o,
  output logic [gmum_pkg::COORD_W-1:0] wall_col_o,
  output logic                         done_res_o
);

  localparam int unsigned CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW     = $clog2(CELLS);
  localparam int unsigned RW     = $clog2(GRID_SIDE);
  localparam int unsigned HALF   = (GRID_SIDE + 1) / 2;
  localparam int unsigned NLABEL = HALF * HALF;
  localparam int unsigned LW     = $clog2(NLABEL);
  localparam int unsigned DW     = LW + 1;
  localparam int unsigned CW     = $clog2(GRID_SIDE + 16);
  localparam int unsigned CW4    = gmum_pkg::COORD_W;

  localparam logic [LW-1:0] LAST_LABEL = LW'(NLABEL - 1);

  // beat decode
  gmum_pkg::dir_e dir;
  logic [CW-1:0]  rr, cc, side;
  logic           start_in, far_in, dir_inc;
  logic [AW-1:0]  row_a, addr_s, off_w, off_f;
  logic [CW4-1:0] wr4, wc4;

  // captured beat
  logic [AW-1:0]  addr_s_q, addr_w_q, addr_f_q;
  logic [CW4-1:0] wall_r_q, wall_c_q;

  // captured cell reads
  logic          start_open_q, wall_open_q, far_open_q;
  logic [LW-1:0] a_q, b_q, hi, lo;

  // sweep
  logic [AW-1:0] idx_q, pend_addr_q;
  logic [RW-1:0] row_q, col_q;
  logic [LW-1:0] lbl_q;
  logic          pend_q;
  logic          scan_last;
  logic          init_open;
  logic [LW-1:0] init_label;

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic          rd_open;
  logic [LW-1:0] rd_label, new_label;
  logic          hit;

  // done tracking
  logic chk_en, chk_first, chk_ok, acc;
  logic merged_q, finished_q;

  // result register
  gmum_pkg::status_e res_status_q;
  logic [CW4-1:0]    res_wr_q, res_wc_q;
  logic              res_done_q;

  // bounds and addresses of the offered beat
  assign dir     = gmum_pkg::dir_e'(direction_i);
  assign rr      = CW'(cell_row_i);
  assign cc      = CW'(cell_col_i);
  assign side    = CW'(GRID_SIDE);
  assign row_a   = AW'(cell_row_i);
  assign addr_s  = AW'(row_a * AW'(GRID_SIDE)) + AW'(cell_col_i);
  assign start_in = (rr < side) && (cc < side);

  always_comb begin
    unique case (dir)
      gmum_pkg::DIR_ROW_INC: begin
        far_in  = (rr + CW'(2)) < side;
        dir_inc = 1'b1;
        off_w   = AW'(GRID_SIDE);
        off_f   = AW'(2 * GRID_SIDE);
        wr4     = cell_row_i + CW4'(1);
        wc4     = cell_col_i;
      end
      gmum_pkg::DIR_COL_INC: begin
        far_in  = (cc + CW'(2)) < side;
        dir_inc = 1'b1;
        off_w   = AW'(1);
        off_f   = AW'(2);
        wr4     = cell_row_i;
        wc4     = cell_col_i + CW4'(1);
      end
      gmum_pkg::DIR_ROW_DEC: begin
        far_in  = rr >= CW'(2);
        dir_inc = 1'b0;
        off_w   = AW'(GRID_SIDE);
        off_f   = AW'(2 * GRID_SIDE);
        wr4     = cell_row_i - CW4'(1);
        wc4     = cell_col_i;
      end
      gmum_pkg::DIR_COL_DEC: begin
        far_in  = cc >= CW'(2);
        dir_inc = 1'b0;
        off_w   = AW'(1);
        off_f   = AW'(2);
        wr4     = cell_row_i;
        wc4     = cell_col_i - CW4'(1);
      end
      default: begin
        far_in  = 1'b0;
        dir_inc = 1'b1;
        off_w   = '0;
        off_f   = '0;
        wr4     = cell_row_i;
        wc4     = cell_col_i;
      end
    endcase
  end

  // capture the beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_s_q <= addr_s;
      addr_w_q <= dir_inc ? addr_s + off_w : addr_s - off_w;
      addr_f_q <= dir_inc ? addr_s + off_f : addr_s - off_f;
      wall_r_q <= wr4;
      wall_c_q <= wc4;
    end
  end

  // RAM read data split
  assign rd_open  = rdata[LW];
  assign rd_label = rdata[LW-1:0];

  // capture start, wall and far cell contents
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_start) begin
      start_open_q <= rd_open;
      a_q          <= rd_label;
    end
    if (cmd_i.cap_wall) begin
      wall_open_q <= rd_open;
    end
    if (cmd_i.cap_far) begin
      far_open_q <= rd_open;
      b_q        <= rd_label;
    end
  end

  assign hi = (a_q > b_q) ? a_q : b_q;
  assign lo = (a_q > b_q) ? b_q : a_q;

  // sweep counters, shared by init and relabel
  assign scan_last  = (idx_q == AW'(CELLS - 1));
  assign init_open  = !row_q[0] && !col_q[0];
  assign init_label = init_open ? lbl_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      row_q  <= '0;
      col_q  <= '0;
      lbl_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.relabel_step;
      if (cmd_i.scan_clr) begin
        idx_q <= '0;
        row_q <= '0;
        col_q <= '0;
        lbl_q <= '0;
      end else if (cmd_i.init_step || cmd_i.relabel_step) begin
        idx_q <= idx_q + AW'(1);
        if (col_q == RW'(GRID_SIDE - 1)) begin
          col_q <= '0;
          row_q <= row_q + RW'(1);
        end else begin
          col_q <= col_q + RW'(1);
        end
        if (cmd_i.init_step && init_open) begin
          lbl_q <= lbl_q + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= idx_q;
  end

  // relabel: a cell carrying the smaller label takes the larger
  assign hit       = rd_open && (rd_label == lo);
  assign new_label = hit ? hi : rd_label;

  // RAM write and read port select
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = {init_open, init_label};
    if (cmd_i.init_step) begin
      we = 1'b1;
    end else if (cmd_i.wall_wr) begin
      we    = 1'b1;
      waddr = addr_w_q;
      wdata = {1'b1, hi};
    end else if (pend_q) begin
      we    = hit;
      waddr = pend_addr_q;
      wdata = {1'b1, hi};
    end

    case (cmd_i.rd_sel)
      gmum_pkg::RSEL_START: raddr = addr_s_q;
      gmum_pkg::RSEL_WALL:  raddr = addr_w_q;
      gmum_pkg::RSEL_FAR:   raddr = addr_f_q;
      default:              raddr = idx_q;
    endcase
  end

  gmum_ram #(
    .DATA_W (DW),
    .DEPTH  (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // done check: every open cell written in the sweep holds the last label
  always_comb begin
    chk_en    = 1'b0;
    chk_first = 1'b0;
    chk_ok    = 1'b1;
    if (cmd_i.init_step) begin
      chk_en    = 1'b1;
      chk_first = (idx_q == '0);
      chk_ok    = !init_open || (init_label == LAST_LABEL);
    end else if (pend_q) begin
      chk_en    = 1'b1;
      chk_first = (pend_addr_q == '0);
      chk_ok    = !rd_open || (new_label == LAST_LABEL);
    end
    acc = chk_first ? chk_ok : (merged_q && chk_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merged_q   <= 1'b0;
      finished_q <= 1'b0;
    end else begin
      if (chk_en) begin
        merged_q <= acc;
      end
      if (cmd_i.fin_load) begin
        finished_q <= acc;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_done_q   <= finished_q;
      if (cmd_i.res_status == gmum_pkg::STATUS_OPENED) begin
        res_wr_q <= wall_r_q;
        res_wc_q <= wall_c_q;
      end else begin
        res_wr_q <= '0;
        res_wc_q <= '0;
      end
    end
  end

  assign status_o   = res_status_q;
  assign wall_row_o = res_wr_q;
  assign wall_col_o = res_wc_q;
  assign done_res_o = res_done_q;

  // status to the controller
  assign stat_o.bounds_ok  = start_in && far_in;
  assign stat_o.finished   = finished_q;
  assign stat_o.scan_last  = scan_last;
  assign stat_o.start_open = start_open_q;
  assign stat_o.merge_ok   = !wall_open_q && far_open_q && (a_q != b_q);

endmodule

// File: rtl/core/grid_maze_union_merge.sv
// ----------------------------------------------------------------------------
// grid_maze_union_merge: maze carving by group merge on a square grid
// Restart beats rebuild the grid; carve beats open a wall between two cells
// of different groups and relabel the smaller group across the grid.
// ----------------------------------------------------------------------------
// A wall-opening carve raises its result after its cell reads, the merge
// decision and one sweep over the cell RAM, one cell per cycle; a restart
// raises its result after one init sweep; other carve results need no sweep.
// Throughput: one beat at a time, set by the one-cell-per-cycle relabel sweep.
// Reset: an init sweep of the cell RAM runs first; no request beat is
// taken until it ends.
module grid_maze_union_merge #(
  parameter int unsigned GRID_SIDE = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gmum_in_if.sink     in_i,
  gmum_out_if.source  out_o
);

  gmum_pkg::ctrl_cmd_t cmd;
  gmum_pkg::dp_stat_t  stat;
  logic                in_ready;
  logic                out_valid;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  // sequencing
  gmum_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // grid storage and arithmetic
  gmum_dp #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cell_row_i  (in_i.cell_row),
    .cell_col_i  (in_i.cell_col),
    .direction_i (in_i.direction),
    .status_o    (out_o.status),
    .wall_row_o  (out_o.wall_row),
    .wall_col_o  (out_o.wall_col),
    .done_res_o  (out_o.done_res)
  );

endmodule
